@@ hdl/bpcr_pkg.sv @@
package bpcr_pkg;

    localparam int STEP_W = 5;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 48;

    localparam logic [IDX_W-1:0] REG_TEMP_CALIB   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_ONE_TWO = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_THREE_SIX = 3'd2;
    localparam logic [IDX_W-1:0] REG_PRESS_SEVEN_NINE = 3'd3;
    localparam logic [IDX_W-1:0] REG_PRESS_TEN_ELEVEN = 3'd4;
    localparam logic [IDX_W-1:0] REG_RATE_GAIN    = 3'd5;

    localparam logic [15:0] RATE_GAIN_RESET = 16'd1280;

    localparam logic [STEP_W-1:0] ST_D_T2     = 5'd0;
    localparam logic [STEP_W-1:0] ST_D_T3     = 5'd1;
    localparam logic [STEP_W-1:0] ST_X_D      = 5'd2;
    localparam logic [STEP_W-1:0] ST_TQ_TQ    = 5'd3;
    localparam logic [STEP_W-1:0] ST_TQ2_TQ   = 5'd4;
    localparam logic [STEP_W-1:0] ST_P6_TQ    = 5'd5;
    localparam logic [STEP_W-1:0] ST_TQ2_P7   = 5'd6;
    localparam logic [STEP_W-1:0] ST_TQ3_P8   = 5'd7;
    localparam logic [STEP_W-1:0] ST_P2_TQ    = 5'd8;
    localparam logic [STEP_W-1:0] ST_TQ2_P3   = 5'd9;
    localparam logic [STEP_W-1:0] ST_TQ3_P4   = 5'd10;
    localparam logic [STEP_W-1:0] ST_C_UP     = 5'd11;
    localparam logic [STEP_W-1:0] ST_UP_UP    = 5'd12;
    localparam logic [STEP_W-1:0] ST_P10_TQ   = 5'd13;
    localparam logic [STEP_W-1:0] ST_U2_B2    = 5'd14;
    localparam logic [STEP_W-1:0] ST_U2_UP    = 5'd15;
    localparam logic [STEP_W-1:0] ST_U3_P11   = 5'd16;
    localparam logic [STEP_W-1:0] ST_DIFF_GAIN = 5'd17;

    localparam logic signed [39:0] PRESS_LOW_Q6  = 40'sd1920000;
    localparam logic signed [39:0] PRESS_HIGH_Q6 = 40'sd8000000;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              wb;
        logic              fin;
        logic              chk;
        logic              rd_old;
        logic              commit;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

@@ hdl/bpcr_ctrl.sv @@
module bpcr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bpcr_pkg::t_sts    i_sts,
    output bpcr_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_WB    = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_RING  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                  r_state, n_state;
    logic [bpcr_pkg::STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step = r_step;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step  = bpcr_pkg::ST_D_T2;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (r_step == bpcr_pkg::ST_U3_P11) begin
                    n_state = S_FIN;
                end else if (r_step == bpcr_pkg::ST_DIFF_GAIN) begin
                    n_state = S_DONE;
                end else begin
                    n_step  = r_step + 5'd1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = S_RING;
            end
            S_RING: begin
                o_cmd.rd_old = 1'b1;
                n_step  = bpcr_pkg::ST_DIFF_GAIN;
                n_state = S_MUL;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= bpcr_pkg::ST_DIFF_GAIN)
        else $error("step counter out of range");

    a_commit_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == S_IDLE)
        else $error("commit did not return to idle");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE && !o_cmd.commit)
        else $error("load outside idle");

endmodule

@@ hdl/bpcr_dp.sv @@
module bpcr_dp #(
    parameter int RATE_WINDOW    = 10,
    parameter int WARMUP_SAMPLES = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bpcr_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [bpcr_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [23:0]                  i_raw_pressure,
    input  logic [23:0]                  i_raw_temperature,
    input  logic                         i_target_shift,
    input  bpcr_pkg::t_cmd               i_cmd,
    output bpcr_pkg::t_sts               o_sts,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_accepted,
    output logic [22:0]                  o_pressure,
    output logic signed [25:0]           o_pressure_rate,
    output logic                         o_ready_res
);

    localparam int PTR_W  = $clog2(RATE_WINDOW);
    localparam int FILL_W = $clog2(RATE_WINDOW + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RATE_WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RATE_WINDOW);
    localparam logic [3:0]        WARM_CNT  = 4'(WARMUP_SAMPLES);

    logic [39:0] r_tcal;
    logic [31:0] r_p12;
    logic [47:0] r_p36;
    logic [31:0] r_p79;
    logic [15:0] r_p1011;
    logic [15:0] r_gain;

    logic [15:0]        t1, t2, p5, p6;
    logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
    logic signed [15:0] p1, p2, p9;
    logic signed [16:0] p1m, p2m;

    assign t1  = r_tcal[15:0];
    assign t2  = r_tcal[31:16];
    assign t3  = $signed(r_tcal[39:32]);
    assign p1  = $signed(r_p12[15:0]);
    assign p2  = $signed(r_p12[31:16]);
    assign p3  = $signed(r_p36[7:0]);
    assign p4  = $signed(r_p36[15:8]);
    assign p5  = r_p36[31:16];
    assign p6  = r_p36[47:32];
    assign p7  = $signed(r_p79[7:0]);
    assign p8  = $signed(r_p79[15:8]);
    assign p9  = $signed(r_p79[31:16]);
    assign p10 = $signed(r_p1011[7:0]);
    assign p11 = $signed(r_p1011[15:8]);
    assign p1m = 17'(p1) - 17'sd16384;
    assign p2m = 17'(p2) - 17'sd16384;

    logic [23:0]        r_up;
    logic               r_sp;
    logic signed [24:0] r_d;
    logic signed [32:0] r_x;
    logic signed [63:0] r_tacc;
    logic signed [23:0] r_tq;
    logic signed [31:0] r_tq2;
    logic signed [38:0] r_tq3;
    logic signed [31:0] r_c;
    logic [31:0]        r_u2;
    logic [31:0]        r_u3;
    logic signed [24:0] r_b2;
    logic signed [63:0] r_acc;
    logic signed [39:0] r_pq;
    logic               r_inr;
    logic [22:0]        r_oldest;
    logic signed [25:0] r_rate;
    logic signed [65:0] r_prod;

    logic [22:0]       r_hist [RATE_WINDOW];
    logic [PTR_W-1:0]  r_ptr;
    logic [FILL_W-1:0] r_fill;
    logic [3:0]        r_count;
    logic              r_ready;
    logic [22:0]       r_lastp;
    logic signed [25:0] r_lastr;

    logic               r_ovalid, r_oacc, r_oready;
    logic [22:0]        r_opress;
    logic signed [25:0] r_orate;

    logic signed [39:0] w_a;
    logic signed [25:0] w_b;
    logic signed [24:0] w_diff;

    assign w_diff = $signed({2'b00, r_pq[22:0]}) - $signed({2'b00, r_oldest});

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_cmd.step)
            bpcr_pkg::ST_D_T2:     begin w_a = 40'(r_d);   w_b = 26'($signed({1'b0, t2})); end
            bpcr_pkg::ST_D_T3:     begin w_a = 40'(r_d);   w_b = 26'(t3); end
            bpcr_pkg::ST_X_D:      begin w_a = 40'(r_x);   w_b = 26'(r_d); end
            bpcr_pkg::ST_TQ_TQ:    begin w_a = 40'(r_tq);  w_b = 26'(r_tq); end
            bpcr_pkg::ST_TQ2_TQ:   begin w_a = 40'(r_tq2); w_b = 26'(r_tq); end
            bpcr_pkg::ST_P6_TQ:    begin w_a = 40'($signed({1'b0, p6})); w_b = 26'(r_tq); end
            bpcr_pkg::ST_TQ2_P7:   begin w_a = 40'(r_tq2); w_b = 26'(p7); end
            bpcr_pkg::ST_TQ3_P8:   begin w_a = 40'(r_tq3); w_b = 26'(p8); end
            bpcr_pkg::ST_P2_TQ:    begin w_a = 40'(p2m);   w_b = 26'(r_tq); end
            bpcr_pkg::ST_TQ2_P3:   begin w_a = 40'(r_tq2); w_b = 26'(p3); end
            bpcr_pkg::ST_TQ3_P4:   begin w_a = 40'(r_tq3); w_b = 26'(p4); end
            bpcr_pkg::ST_C_UP:     begin w_a = 40'(r_c);   w_b = 26'($signed({1'b0, r_up})); end
            bpcr_pkg::ST_UP_UP: begin
                w_a = 40'($signed({1'b0, r_up}));
                w_b = 26'($signed({1'b0, r_up}));
            end
            bpcr_pkg::ST_P10_TQ:   begin w_a = 40'(r_tq);  w_b = 26'(p10); end
            bpcr_pkg::ST_U2_B2:    begin w_a = 40'($signed({1'b0, r_u2})); w_b = 26'(r_b2); end
            bpcr_pkg::ST_U2_UP: begin
                w_a = 40'($signed({1'b0, r_u2}));
                w_b = 26'($signed({1'b0, r_up}));
            end
            bpcr_pkg::ST_U3_P11:   begin w_a = 40'($signed({1'b0, r_u3})); w_b = 26'(p11); end
            bpcr_pkg::ST_DIFF_GAIN: begin
                w_a = 40'(w_diff);
                w_b = 26'($signed({1'b0, r_gain}));
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    logic signed [63:0] w_tsum;
    logic signed [39:0] w_t24w;
    logic signed [31:0] w_t24;
    logic signed [65:0] w_rsum;
    logic signed [57:0] w_rw;
    logic signed [25:0] w_rsat;
    logic signed [63:0] w_addend;

    always_comb begin
        w_tsum = r_tacc + 64'(r_prod);
        w_t24w = 40'(w_tsum >>> 24);
        if (w_t24w > 40'sd2147483647) begin
            w_t24 = 32'sh7fffffff;
        end else if (w_t24w < -40'sd2147483648) begin
            w_t24 = 32'sh80000000;
        end else begin
            w_t24 = 32'(w_t24w);
        end
        w_rsum = r_prod + 66'sd128;
        w_rw   = 58'(w_rsum >>> 8);
        if (w_rw > 58'sd33554431) begin
            w_rsat = 26'sh1ffffff;
        end else if (w_rw < -58'sd33554432) begin
            w_rsat = 26'sh2000000;
        end else begin
            w_rsat = 26'(w_rw);
        end
        w_addend = '0;
        unique case (i_cmd.step)
            bpcr_pkg::ST_TQ2_P7: w_addend = 64'(r_prod) <<< 6;
            bpcr_pkg::ST_TQ3_P8: w_addend = 64'(r_prod >>> 1);
            bpcr_pkg::ST_C_UP:   w_addend = 64'(r_prod >>> 2);
            bpcr_pkg::ST_U2_B2:  w_addend = 64'(r_prod >>> 10);
            bpcr_pkg::ST_U3_P11: w_addend = 64'(r_prod) <<< 5;
            default:             w_addend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_up <= i_raw_pressure;
            r_sp <= i_target_shift;
            r_d  <= $signed({1'b0, i_raw_temperature}) - $signed({1'b0, t1, 8'h00});
        end
        if (i_cmd.mul) begin
            r_prod <= w_a * w_b;
        end
        if (i_cmd.wb) begin
            unique case (i_cmd.step)
                bpcr_pkg::ST_D_T2:   r_tacc <= (64'(r_prod) <<< 18) + 64'sd8388608;
                bpcr_pkg::ST_D_T3:   r_x <= 33'(r_prod);
                bpcr_pkg::ST_X_D:    r_tq <= 24'(w_t24 >>> 8);
                bpcr_pkg::ST_TQ_TQ:  r_tq2 <= 32'(r_prod >>> 16);
                bpcr_pkg::ST_TQ2_TQ: r_tq3 <= 39'(r_prod >>> 16);
                bpcr_pkg::ST_P6_TQ:
                    r_acc <= (64'($signed({1'b0, p5})) <<< 33) + (64'(r_prod) <<< 8);
                bpcr_pkg::ST_P2_TQ:  r_c <= (32'(p1m) <<< 12) + 32'(r_prod >>> 13);
                bpcr_pkg::ST_TQ2_P3: r_c <= r_c + 32'(r_prod >>> 16);
                bpcr_pkg::ST_TQ3_P4: r_c <= r_c + 32'(r_prod >>> 21);
                bpcr_pkg::ST_UP_UP:  r_u2 <= r_prod[47:16];
                bpcr_pkg::ST_P10_TQ: r_b2 <= (25'(p9) <<< 8) + 25'(r_prod >>> 8);
                bpcr_pkg::ST_U2_UP:  r_u3 <= r_prod[55:24];
                bpcr_pkg::ST_DIFF_GAIN: r_rate <= w_rsat;
                default:             r_acc <= r_acc + w_addend;
            endcase
        end
        if (i_cmd.fin) begin
            r_pq <= 40'((r_acc + 64'sd8388608) >>> 24);
        end
        if (i_cmd.chk) begin
            r_inr <= (r_pq > bpcr_pkg::PRESS_LOW_Q6) && (r_pq < bpcr_pkg::PRESS_HIGH_Q6);
        end
        if (i_cmd.rd_old) begin
            r_oldest <= r_hist[r_ptr];
        end
        if (i_cmd.commit && r_inr) begin
            r_hist[r_ptr] <= r_pq[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal  <= '0;
            r_p12   <= '0;
            r_p36   <= '0;
            r_p79   <= '0;
            r_p1011 <= '0;
            r_gain  <= bpcr_pkg::RATE_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpcr_pkg::REG_TEMP_CALIB:       r_tcal  <= i_cfg_wdata[39:0];
                bpcr_pkg::REG_PRESS_ONE_TWO:    r_p12   <= i_cfg_wdata[31:0];
                bpcr_pkg::REG_PRESS_THREE_SIX:  r_p36   <= i_cfg_wdata[47:0];
                bpcr_pkg::REG_PRESS_SEVEN_NINE: r_p79   <= i_cfg_wdata[31:0];
                bpcr_pkg::REG_PRESS_TEN_ELEVEN: r_p1011 <= i_cfg_wdata[15:0];
                bpcr_pkg::REG_RATE_GAIN:        r_gain  <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    logic               n_ready;
    logic [3:0]         n_count;
    logic signed [25:0] n_rate;

    always_comb begin
        n_count = (r_count < 4'd15) ? r_count + 4'd1 : r_count;
        n_ready = r_ready || (n_count >= WARM_CNT);
        n_rate  = (r_fill == FILL_FULL && !r_sp) ? r_rate : 26'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_fill   <= '0;
            r_count  <= '0;
            r_ready  <= 1'b0;
            r_lastp  <= '0;
            r_lastr  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_ovalid <= 1'b1;
                if (r_inr) begin
                    r_ptr   <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                    if (r_fill != FILL_FULL) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_count <= n_count;
                    r_ready <= n_ready;
                    r_lastp <= r_pq[22:0];
                    r_lastr <= n_rate;
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_oacc <= r_inr;
            if (r_inr) begin
                r_opress <= r_pq[22:0];
                r_orate  <= n_rate;
                r_oready <= n_ready;
            end else begin
                r_opress <= r_lastp;
                r_orate  <= r_lastr;
                r_oready <= r_ready;
            end
        end
    end

    assign o_sts.out_free   = !r_ovalid || i_ready;
    assign o_valid          = r_ovalid;
    assign o_accepted       = r_oacc;
    assign o_pressure       = r_opress;
    assign o_pressure_rate  = r_orate;
    assign o_ready_res      = r_oready;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("ring pointer out of range");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count out of range");

    a_ready_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_count >= WARM_CNT)
        else $error("ready set before warmup");

    a_rate_zero_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_fill != FILL_FULL) |=> r_lastr == 26'sd0)
        else $error("rate nonzero while ring fills");

endmodule

@@ hdl/baro_pressure_compensate_rate.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata: raw_pressure[23:0], raw_temperature[47:24]; tuser: target_shift
// m_axis    out        tdata: pressure[22:0], pressure_rate[48:23]; tuser: accepted, ready_res
// cfg       in         i_cfg_we, i_cfg_idx, i_cfg_wdata (register write, no read-back)
//
// Each sample is worked through the single shared 40x26 multiplier, which runs 18 products
// in turn, each as a multiply step and a write-back step, plus five control steps. A new
// sample is taken only once the previous result sits in the output register, and a result
// waits until the output register is free. Reset is synchronous and active low; it clears
// control state and the calibration coefficients and sets the rate gain to its reset value.
// A stalled output holds its result while the next sample is computed.
module baro_pressure_compensate_rate #(
    parameter int RATE_WINDOW    = 10,
    parameter int WARMUP_SAMPLES = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,  // raw_pressure, raw_temperature
    input  logic [0:0]                  s_axis_tuser,  // target_shift
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [55:0]                 m_axis_tdata,  // pressure, pressure_rate, zero pad
    output logic [1:0]                  m_axis_tuser,  // accepted, ready_res
    input  logic                        i_cfg_we,
    input  logic [bpcr_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [bpcr_pkg::CFG_W-1:0]  i_cfg_wdata
);

    bpcr_pkg::t_cmd w_cmd;
    bpcr_pkg::t_sts w_sts;

    logic               w_acc, w_rdy;
    logic [22:0]        w_press;
    logic signed [25:0] w_rate;

    bpcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpcr_dp #(
        .RATE_WINDOW    (RATE_WINDOW),
        .WARMUP_SAMPLES (WARMUP_SAMPLES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_raw_pressure      (s_axis_tdata[23:0]),
        .i_raw_temperature   (s_axis_tdata[47:24]),
        .i_target_shift      (s_axis_tuser[0]),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_valid             (m_axis_tvalid),
        .i_ready             (m_axis_tready),
        .o_accepted          (w_acc),
        .o_pressure          (w_press),
        .o_pressure_rate     (w_rate),
        .o_ready_res         (w_rdy)
    );

    assign m_axis_tdata = {7'd0, w_rate, w_press};
    assign m_axis_tuser = {w_rdy, w_acc};

endmodule

@@ tb/tb_baro_pressure_compensate_rate.sv @@
module tb_baro_pressure_compensate_rate;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_LEN  = 10;
    localparam int WARMUP    = 10;
    localparam longint LOW_Q6  = 1920000;
    localparam longint HIGH_Q6 = 8000000;
    localparam longint RMAX    = 33554431;
    localparam longint RMIN    = -33554432;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_RANDOM    = 2160;

    typedef struct packed {
        logic        acc;
        logic [22:0] pres;
        logic [25:0] rate;
        logic        rdy;
    } t_sample_res;

    typedef struct {
        logic [23:0] up;
        logic [23:0] ut;
        logic        sp;
        logic        typed;
        t_sample_res res;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata = '0;
    logic [0:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [55:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              i_cfg_we = 1'b0;
    logic [bpcr_pkg::IDX_W-1:0]  i_cfg_idx = '0;
    logic [bpcr_pkg::CFG_W-1:0]  i_cfg_wdata = '0;

    baro_pressure_compensate_rate dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor copy of the calibration and the ring state.
    logic [39:0] cal_temp;
    logic [31:0] cal_p12;
    logic [47:0] cal_p36;
    logic [31:0] cal_p79;
    logic [15:0] cal_p1011;
    logic [15:0] cal_gain;
    logic [22:0] ring_mem [16];
    int          ring_ptr, ring_fill, warm_count;
    logic        warm_flag;
    logic [22:0] held_pres;
    logic [25:0] held_rate;

    t_sample_res expected_results[$];
    t_stim_row   row_q[$];
    bit          failed = 1'b0;
    int          send_idle = 0, recv_idle = 0;
    bit          want_hold = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;

    function automatic longint compensated_q6(logic [23:0] raw_p, logic [23:0] raw_t);
        longint up, ut, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        longint d, t24, tq, tq2, tq3, acc, c, u2, u3;
        logic signed [7:0]  s8;
        logic signed [15:0] s16;
        up = raw_p;
        ut = raw_t;
        t1 = cal_temp[15:0];
        t2 = cal_temp[31:16];
        s8 = cal_temp[39:32];   t3 = s8;
        s16 = cal_p12[15:0];    p1 = s16;
        s16 = cal_p12[31:16];   p2 = s16;
        s8 = cal_p36[7:0];      p3 = s8;
        s8 = cal_p36[15:8];     p4 = s8;
        p5 = cal_p36[31:16];
        p6 = cal_p36[47:32];
        s8 = cal_p79[7:0];      p7 = s8;
        s8 = cal_p79[15:8];     p8 = s8;
        s16 = cal_p79[31:16];   p9 = s16;
        s8 = cal_p1011[7:0];    p10 = s8;
        s8 = cal_p1011[15:8];   p11 = s8;
        d = ut - t1 * 256;
        t24 = (d * t2 * 262144 + d * d * t3 + 8388608) >>> 24;
        if (t24 > 64'sd2147483647) t24 = 64'sd2147483647;
        if (t24 < -64'sd2147483648) t24 = -64'sd2147483648;
        tq = t24 >>> 8;
        tq2 = (tq * tq) >>> 16;
        tq3 = (tq2 * tq) >>> 16;
        acc = p5 * 64'sd8589934592 + p6 * tq * 256 + p7 * tq2 * 64 + ((p8 * tq3) >>> 1);
        c = (p1 - 16384) * 4096 + (((p2 - 16384) * tq) >>> 13)
            + ((p3 * tq2) >>> 16) + ((p4 * tq3) >>> 21);
        acc += (up * c) >>> 2;
        u2 = (up * up) >>> 16;
        acc += (u2 * (p9 * 256 + ((p10 * tq) >>> 8))) >>> 10;
        u3 = (u2 * up) >>> 24;
        acc += u3 * p11 * 32;
        return (acc + 8388608) >>> 24;
    endfunction

    function automatic t_sample_res predict_sample(logic [23:0] raw_p, logic [23:0] raw_t,
                                                   logic sp);
        t_sample_res r;
        longint p, oldest, rate;
        p = compensated_q6(raw_p, raw_t);
        r.acc = 1'b0;
        if (p > LOW_Q6 && p < HIGH_Q6) begin
            rate = 0;
            oldest = ring_mem[ring_ptr];
            ring_mem[ring_ptr] = p[22:0];
            ring_ptr = (ring_ptr + 1 >= RING_LEN) ? 0 : ring_ptr + 1;
            if (ring_fill < RING_LEN) begin
                ring_fill++;
            end else if (!sp) begin
                rate = ((p - oldest) * longint'(cal_gain) + 128) >>> 8;
                if (rate > RMAX) rate = RMAX;
                if (rate < RMIN) rate = RMIN;
            end
            held_rate = rate[25:0];
            held_pres = p[22:0];
            if (warm_count < 15) warm_count++;
            if (warm_count >= WARMUP) warm_flag = 1'b1;
            r.acc = 1'b1;
        end
        r.pres = held_pres;
        r.rate = held_rate;
        r.rdy = warm_flag;
        return r;
    endfunction

    // Transfers on both channels are sampled here, before this edge's updates land.
    always @(posedge i_clk) begin
        t_sample_res got, want;
        t_stim_row   row;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.acc = m_axis_tuser[0];
                got.rdy = m_axis_tuser[1];
                got.pres = m_axis_tdata[22:0];
                got.rate = m_axis_tdata[48:23];
                if (expected_results.size() == 0) begin
                    failed = 1'b1;
                    $display("%0t unexpected result %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.acc !== want.acc)
                        $display("%0t accepted exp %0d got %0d", $time, want.acc, got.acc);
                    if (got.pres !== want.pres)
                        $display("%0t pressure exp %0d got %0d", $time, want.pres, got.pres);
                    if (got.rate !== want.rate)
                        $display("%0t rate exp %0d got %0d", $time,
                                 $signed(want.rate), $signed(got.rate));
                    if (got.rdy !== want.rdy)
                        $display("%0t ready exp %0d got %0d", $time, want.rdy, got.rdy);
                    if (got !== want) failed = 1'b1;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                row = row_q.pop_front();
                want = predict_sample(row.up, row.ut, row.sp);
                if (row.typed) begin
                    if (want !== row.res)
                        $display("%0t table row disagrees with prediction", $time);
                    want = row.res;
                end
                expected_results.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (want_hold && hold_left == 0) begin
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left <= -1;
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_sample(logic [23:0] up, logic [23:0] ut, logic sp, logic typed,
                               t_sample_res res);
        t_stim_row row;
        row.up = up; row.ut = ut; row.sp = sp; row.typed = typed; row.res = res;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        row_q.push_back(row);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ut, up};
        s_axis_tuser <= sp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [bpcr_pkg::IDX_W-1:0] idx,
                             logic [bpcr_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            bpcr_pkg::REG_TEMP_CALIB:       cal_temp = val[39:0];
            bpcr_pkg::REG_PRESS_ONE_TWO:    cal_p12 = val[31:0];
            bpcr_pkg::REG_PRESS_THREE_SIX:  cal_p36 = val[47:0];
            bpcr_pkg::REG_PRESS_SEVEN_NINE: cal_p79 = val[31:0];
            bpcr_pkg::REG_PRESS_TEN_ELEVEN: cal_p1011 = val[15:0];
            bpcr_pkg::REG_RATE_GAIN:        cal_gain = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic load_calibration(logic [39:0] t, logic [31:0] a, logic [47:0] b,
                                    logic [31:0] c, logic [15:0] e, logic [15:0] g);
        write_reg(bpcr_pkg::REG_TEMP_CALIB, 48'(t));
        write_reg(bpcr_pkg::REG_PRESS_ONE_TWO, 48'(a));
        write_reg(bpcr_pkg::REG_PRESS_THREE_SIX, b);
        write_reg(bpcr_pkg::REG_PRESS_SEVEN_NINE, 48'(c));
        write_reg(bpcr_pkg::REG_PRESS_TEN_ELEVEN, 48'(e));
        write_reg(bpcr_pkg::REG_RATE_GAIN, 48'(g));
        i_cfg_we <= 1'b0;
    endtask

    // Calibration that keeps most samples inside the valid pressure band.
    task automatic load_plausible(logic [15:0] g);
        logic [15:0] p1, p2, p5, p6, p9;
        p1 = 16'(16384 + $urandom_range(3000));
        p2 = 16'(16384 + $urandom_range(16) - 8);
        p5 = 16'($urandom_range(9000, 4000));
        p6 = 16'($urandom_range(255));
        p9 = 16'($urandom_range(2000) - 1000);
        load_calibration({8'($urandom), 16'($urandom), 16'($urandom)}, {p2, p1},
                         {p6, p5, 8'($urandom), 8'($urandom)},
                         {p9, 8'($urandom), 8'($urandom)}, 16'($urandom), g);
    endtask

    initial begin
        t_stim_row   dir_rows[$];
        t_stim_row   r;
        t_sample_res rej0;
        int          phase, k, n;
        logic [15:0] g;

        cal_temp = '0; cal_p12 = '0; cal_p36 = '0; cal_p79 = '0; cal_p1011 = '0;
        cal_gain = bpcr_pkg::RATE_GAIN_RESET;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        ring_ptr = 0; ring_fill = 0; warm_count = 0; warm_flag = 1'b0;
        held_pres = '0; held_rate = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With cleared calibration every sample falls below the band.
        rej0 = '0;
        dir_rows = '{
            '{24'h000000, 24'h000000, 1'b0, 1'b1, rej0},
            '{24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, rej0},
            '{24'h800000, 24'h000001, 1'b0, 1'b1, rej0}
        };
        foreach (dir_rows[i])
            send_sample(dir_rows[i].up, dir_rows[i].ut, dir_rows[i].sp, 1'b1, dir_rows[i].res);
        drain();

        load_calibration('0, {16'd16384, 16'd18384}, {16'd0, 16'd6000, 16'd0},
                         '0, '0, bpcr_pkg::RATE_GAIN_RESET);
        for (k = 0; k < 20; k++) begin
            r.up = (k % 3 == 0) ? 24'hFFFFFF : (k % 3 == 1) ? 24'h000000 : 24'($urandom);
            r.ut = (k % 2 == 0) ? 24'hFFFFFF : 24'h000000;
            r.sp = (k == 12 || k == 15 || k == 4);
            send_sample(r.up, r.ut, r.sp, 1'b0, rej0);
        end
        drain();

        for (phase = 0; phase < 9; phase++) begin
            send_idle = (phase < 3) ? 29 : (phase < 6) ? 64 : 0;
            recv_idle = (phase < 3) ? 64 : (phase < 6) ? 29 : 0;
            g = (phase == 0) ? 16'hFFFF : (phase == 1) ? 16'h0000 : 16'($urandom);
            n = N_RANDOM / 9;
            if (phase == 4) begin
                load_calibration('1, '1, '1, '1, '1, 16'hFFFF);
                n = 40;
            end else if (phase == 7) begin
                load_calibration({8'($urandom), 32'($urandom)}, $urandom,
                                 {16'($urandom), 32'($urandom)}, $urandom, 16'($urandom), g);
                n = 40;
            end else begin
                load_plausible(g);
            end
            if (phase == 6) want_hold = 1'b1;
            for (k = 0; k < n; k++) begin
                send_sample(24'($urandom), 24'($urandom), ($urandom_range(7) == 0), 1'b0,
                            rej0);
                want_hold = 1'b0;
            end
            drain();
        end

        if (row_q.size() != 0 || expected_results.size() != 0) failed = 1'b1;
        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bpcr_pkg.sv
hdl/bpcr_ctrl.sv
hdl/bpcr_dp.sv
hdl/baro_pressure_compensate_rate.sv
tb/tb_baro_pressure_compensate_rate.sv
